// ===== rtl/ssmr_pkg.sv =====
// ============================================================================
// ssmr_pkg
// Shared types and constants of the supervisor state merge reduction unit.
// ============================================================================
package ssmr_pkg;

    localparam int MAX_STATES_DEF = 64;
    localparam int NUM_EVENTS_DEF = 32;
    localparam int OUT_LIMIT      = 64;

    localparam int CFG_W          = 7;
    localparam int CFG_RESET      = 64;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // command codes
    localparam logic [1:0] CMD_LOAD_MARK   = 2'd0;
    localparam logic [1:0] CMD_LOAD_TRANS  = 2'd1;
    localparam logic [1:0] CMD_LOAD_FORBID = 2'd2;
    localparam logic [1:0] CMD_RUN         = 2'd3;

    // register index taken from paddr[2]
    localparam logic REG_NUM_STATES = 1'b0;

    // marking codes
    localparam logic [3:0] MARK_RESET   = 4'h2;
    localparam logic [3:0] MARK_LO_MASK = 4'h3;
    localparam logic [3:0] MARK_HI_MASK = 4'hc;
    localparam logic [4:0] CONFLICT_LO  = 5'h05;
    localparam logic [4:0] CONFLICT_HI  = 5'h14;

    // memory banks: working copy and checkpoint
    localparam logic BANK_LIVE  = 1'b0;
    localparam logic BANK_SAVED = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_COPY,
        S_I_RD,
        S_I_CHK,
        S_J_RD,
        S_J_CHK,
        S_Q_RD,
        S_Q_GOT,
        S_RA,
        S_RB,
        S_RB2,
        S_CMP,
        S_EV,
        S_CP_EV,
        S_TA,
        S_TB,
        S_F_RD,
        S_F_CHK,
        S_LINK,
        S_OUT,
        S_OUT_WAIT
    } eng_state_t;

    typedef enum logic [1:0] {
        FR_C1,
        FR_C2,
        FR_OUT
    } find_ret_t;

    typedef enum logic [1:0] {
        CP_INIT,
        CP_LO,
        CP_HI
    } copy_mode_t;

endpackage

// ===== rtl/ssmr_if.sv =====
// ============================================================================
// ssmr_in_if / ssmr_out_if
// Valid/ready channels carrying command words and result words.
// ============================================================================
interface ssmr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] state_index;
    logic [4:0] event_index;
    logic [5:0] target_state;
    logic       ctrl_mark;
    logic       plant_mark;

    modport source (output valid, command, state_index, event_index, target_state,
                    ctrl_mark, plant_mark, input ready);
    modport sink   (input valid, command, state_index, event_index, target_state,
                    ctrl_mark, plant_mark, output ready);
endinterface

interface ssmr_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] result_state;
    logic [5:0] cluster_representative;
    logic       last_result;

    modport source (output valid, result_state, cluster_representative, last_result,
                    input ready);
    modport sink   (input valid, result_state, cluster_representative, last_result,
                    output ready);
endinterface

// ===== rtl/ssmr_engine.sv =====
// ============================================================================
// ssmr_engine
// Table memories, checkpoint banks, pair queue and the merge sequencer.
// ============================================================================
module ssmr_engine #(
    parameter int MAX_STATES = 64,
    parameter int NUM_EVENTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ssmr_in_if.sink                            items,
    ssmr_out_if.source                         results,
    input  logic [$clog2(MAX_STATES+1)-1:0]    n_used
);
    import ssmr_pkg::*;

    localparam int SW     = $clog2(MAX_STATES);
    localparam int CW     = $clog2(MAX_STATES + 1);
    localparam int EW     = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int EC     = $clog2(NUM_EVENTS + 1);
    localparam int ROW_W  = 2 * NUM_EVENTS + 4;
    localparam int RA     = SW + 1;
    localparam int TA     = 1 + SW + EW;
    localparam int RDEPTH = 2 ** RA;
    localparam int TDEPTH = 2 ** TA;
    localparam logic [ROW_W-1:0] ROW_RESET = {MARK_RESET, {(2*NUM_EVENTS){1'b0}}};
    localparam logic [ROW_W-1:0] ROW_ALL   = '1;

    // ---------------- memories ----------------
    logic [ROW_W-1:0] row_mem [RDEPTH];
    logic             row_valid_reg [RDEPTH];
    logic [ROW_W-1:0] row_rdata_reg;
    logic             row_rvalid_reg;
    logic             row_we;
    logic [RA-1:0]    row_waddr, row_raddr;
    logic [ROW_W-1:0] row_wmask, row_wdata, row_eff_mask, row_eff_data, row_rd;

    logic [SW-1:0]    tgt_mem [TDEPTH];
    logic [SW-1:0]    tgt_rdata_reg;
    logic             tgt_we;
    logic [TA-1:0]    tgt_waddr, tgt_raddr;
    logic [SW-1:0]    tgt_wdata;

    logic [SW-1:0]    par_mem [RDEPTH];
    logic [SW-1:0]    par_rdata_reg;
    logic             par_we;
    logic [RA-1:0]    par_waddr, par_raddr;
    logic [SW-1:0]    par_wdata;

    logic [2*SW-1:0]  que_mem [MAX_STATES];
    logic [2*SW-1:0]  que_rdata_reg;
    logic             que_we;
    logic [SW-1:0]    que_waddr, que_raddr;
    logic [2*SW-1:0]  que_wdata;

    // unwritten rows read as their reset value; the first write fills the rest
    assign row_eff_mask = row_valid_reg[row_waddr] ? row_wmask : ROW_ALL;
    assign row_eff_data = (row_wdata & row_wmask) | (ROW_RESET & ~row_wmask);
    assign row_rd       = row_rvalid_reg ? row_rdata_reg : ROW_RESET;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            for (int b = 0; b < ROW_W; b++)
            begin
                if (row_eff_mask[b])
                    row_mem[row_waddr][b] <= row_eff_data[b];
            end
        end
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RDEPTH; r++)
                row_valid_reg[r] <= 1'b0;
            row_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (row_we)
                row_valid_reg[row_waddr] <= 1'b1;
            row_rvalid_reg <= row_valid_reg[row_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[tgt_waddr] <= tgt_wdata;
        tgt_rdata_reg <= tgt_mem[tgt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        par_rdata_reg <= par_mem[par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (que_we)
            que_mem[que_waddr] <= que_wdata;
        que_rdata_reg <= que_mem[que_raddr];
    end

    // ---------------- sequencer registers ----------------
    eng_state_t          st_reg, st_next;
    find_ret_t           fret_reg, fret_next;
    copy_mode_t          cp_mode_reg, cp_mode_next;
    logic [CW-1:0]       i_reg, i_next, j_reg, j_next, qn_reg, qn_next, k_reg, k_next;
    logic [CW-1:0]       s_reg, s_next;
    logic [SW-1:0]       a_reg, a_next, b_reg, b_next, x_reg, x_next;
    logic [SW-1:0]       t1_reg, t1_next, t2_reg, t2_next, c1_reg, c1_next;
    logic [SW-1:0]       fx_reg, fx_next;
    logic [NUM_EVENTS-1:0] en_a_reg, en_a_next, fb_a_reg, fb_a_next;
    logic [NUM_EVENTS-1:0] en_b_reg, en_b_next, fb_b_reg, fb_b_next;
    logic [3:0]          mk_a_reg, mk_a_next, mk_b_reg, mk_b_next;
    logic [EC-1:0]       e_reg, e_next, t_reg, t_next;
    logic                ok_reg, ok_next, fin_reg, fin_next;
    logic                out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [5:0]          out_state_reg, out_state_next, out_rep_reg, out_rep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fret_reg      <= fret_next;
        cp_mode_reg   <= cp_mode_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        qn_reg        <= qn_next;
        k_reg         <= k_next;
        s_reg         <= s_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        x_reg         <= x_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        c1_reg        <= c1_next;
        fx_reg        <= fx_next;
        en_a_reg      <= en_a_next;
        fb_a_reg      <= fb_a_next;
        mk_a_reg      <= mk_a_next;
        en_b_reg      <= en_b_next;
        fb_b_reg      <= fb_b_next;
        mk_b_reg      <= mk_b_next;
        e_reg         <= e_next;
        t_reg         <= t_next;
        ok_reg        <= ok_next;
        fin_reg       <= fin_next;
        out_last_reg  <= out_last_next;
        out_state_reg <= out_state_next;
        out_rep_reg   <= out_rep_next;
    end

    // ---------------- input decode ----------------
    logic [SW+5:0] st_wide, tg_wide;
    logic [EW+4:0] ev_wide;
    logic [SW-1:0] st_idx, tg_idx;
    logic [EW-1:0] ev_idx;
    logic          st_ok, tg_ok, ev_ok;
    logic [3:0]    mark_base, mark_code;
    logic [NUM_EVENTS-1:0] ev_onehot;

    assign st_wide = {{SW{1'b0}}, items.state_index};
    assign tg_wide = {{SW{1'b0}}, items.target_state};
    assign ev_wide = {{EW{1'b0}}, items.event_index};
    assign st_idx  = st_wide[SW-1:0];
    assign tg_idx  = tg_wide[SW-1:0];
    assign ev_idx  = ev_wide[EW-1:0];
    assign st_ok   = 32'(items.state_index) < 32'(MAX_STATES);
    assign tg_ok   = 32'(items.target_state) < 32'(MAX_STATES);
    assign ev_ok   = 32'(items.event_index) < 32'(NUM_EVENTS);
    assign mark_base = {2'b00, 1'b1, items.ctrl_mark};
    assign mark_code = items.plant_mark ? {mark_base[1:0], 2'b00} : mark_base;

    always_comb
    begin
        ev_onehot = '0;
        ev_onehot[ev_idx] = 1'b1;
    end

    // ---------------- merge helpers ----------------
    logic [EW-1:0]  e_idx, t_idx, tm1_idx;
    logic [EC-1:0]  tm1;
    logic           ea, eb, compat, cp_commit, src_bank, dst_bank;
    logic [4:0]     sum_lo, sum_hi;
    logic [SW-1:0]  lnk_lo, lnk_hi, s_idx;
    logic [SW+5:0]  s_wide, fx_wide;
    logic [NUM_EVENTS-1:0] e_onehot;

    assign e_idx   = e_reg[EW-1:0];
    assign t_idx   = t_reg[EW-1:0];
    assign tm1     = t_reg - EC'(1);
    assign tm1_idx = tm1[EW-1:0];
    assign ea      = en_a_reg[e_idx];
    assign eb      = en_b_reg[e_idx];
    assign sum_lo  = {1'b0, mk_a_reg & MARK_LO_MASK} + {1'b0, mk_b_reg & MARK_LO_MASK};
    assign sum_hi  = {1'b0, mk_a_reg & MARK_HI_MASK} + {1'b0, mk_b_reg & MARK_HI_MASK};
    assign compat  = (sum_lo != CONFLICT_LO) && (sum_hi != CONFLICT_HI) &&
                     !(|(fb_a_reg & en_b_reg)) && !(|(fb_b_reg & en_a_reg));
    assign cp_commit = (cp_mode_reg == CP_INIT) || ok_reg;
    assign src_bank  = cp_commit ? BANK_LIVE : BANK_SAVED;
    assign dst_bank  = cp_commit ? BANK_SAVED : BANK_LIVE;
    assign lnk_lo  = (c1_reg < fx_reg) ? c1_reg : fx_reg;
    assign lnk_hi  = (c1_reg < fx_reg) ? fx_reg : c1_reg;
    assign s_idx   = s_reg[SW-1:0];
    assign s_wide  = {6'b0, s_idx};
    assign fx_wide = {6'b0, fx_reg};

    always_comb
    begin
        e_onehot = '0;
        e_onehot[e_idx] = 1'b1;
    end

    assign items.ready                   = (st_reg == S_IDLE);
    assign results.valid                 = out_valid_reg;
    assign results.result_state          = out_state_reg;
    assign results.cluster_representative = out_rep_reg;
    assign results.last_result           = out_last_reg;

    always_comb
    begin
        st_next        = st_reg;
        fret_next      = fret_reg;
        cp_mode_next   = cp_mode_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        qn_next        = qn_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        c1_next        = c1_reg;
        fx_next        = fx_reg;
        en_a_next      = en_a_reg;
        fb_a_next      = fb_a_reg;
        mk_a_next      = mk_a_reg;
        en_b_next      = en_b_reg;
        fb_b_next      = fb_b_reg;
        mk_b_next      = mk_b_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        ok_next        = ok_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_state_next = out_state_reg;
        out_rep_next   = out_rep_reg;

        row_we    = 1'b0;
        row_waddr = '0;
        row_raddr = '0;
        row_wmask = ROW_ALL;
        row_wdata = '0;
        tgt_we    = 1'b0;
        tgt_waddr = '0;
        tgt_raddr = '0;
        tgt_wdata = '0;
        par_we    = 1'b0;
        par_waddr = '0;
        par_raddr = '0;
        par_wdata = '0;
        que_we    = 1'b0;
        que_waddr = '0;
        que_raddr = '0;
        que_wdata = '0;

        case (st_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    case (items.command)
                        CMD_LOAD_MARK:
                        begin
                            if (st_ok)
                            begin
                                row_we    = 1'b1;
                                row_waddr = {BANK_LIVE, st_idx};
                                row_wmask = {4'hf, {(2*NUM_EVENTS){1'b0}}};
                                row_wdata = {mark_code, {(2*NUM_EVENTS){1'b0}}};
                            end
                        end
                        CMD_LOAD_TRANS:
                        begin
                            if (st_ok && ev_ok && tg_ok)
                            begin
                                row_we    = 1'b1;
                                row_waddr = {BANK_LIVE, st_idx};
                                row_wmask = {4'h0, {NUM_EVENTS{1'b0}}, ev_onehot};
                                row_wdata = {4'h0, {NUM_EVENTS{1'b0}}, ev_onehot};
                                tgt_we    = 1'b1;
                                tgt_waddr = {BANK_LIVE, st_idx, ev_idx};
                                tgt_wdata = tg_idx;
                            end
                        end
                        CMD_LOAD_FORBID:
                        begin
                            if (st_ok && ev_ok)
                            begin
                                row_we    = 1'b1;
                                row_waddr = {BANK_LIVE, st_idx};
                                row_wmask = {4'h0, ev_onehot, {NUM_EVENTS{1'b0}}};
                                row_wdata = {4'h0, ev_onehot, {NUM_EVENTS{1'b0}}};
                            end
                        end
                        default:
                        begin
                            cp_mode_next = CP_INIT;
                            x_next       = '0;
                            t_next       = '0;
                            st_next      = S_COPY;
                        end
                    endcase
                end
            end

            // one state: rows and parent at t=0/1, targets pipelined over t
            S_COPY:
            begin
                if (32'(t_reg) < 32'(NUM_EVENTS))
                    tgt_raddr = {src_bank, x_reg, t_idx};
                if (t_reg != '0)
                begin
                    tgt_we    = 1'b1;
                    tgt_waddr = {dst_bank, x_reg, tm1_idx};
                    tgt_wdata = tgt_rdata_reg;
                end
                if (t_reg == '0)
                begin
                    row_raddr = {src_bank, x_reg};
                    if (cp_mode_reg == CP_INIT)
                    begin
                        par_we    = 1'b1;
                        par_waddr = {BANK_LIVE, x_reg};
                        par_wdata = x_reg;
                    end
                    else
                        par_raddr = {src_bank, x_reg};
                end
                if (t_reg == EC'(1))
                begin
                    row_we    = 1'b1;
                    row_waddr = {dst_bank, x_reg};
                    row_wdata = row_rd;
                    par_we    = 1'b1;
                    par_waddr = {dst_bank, x_reg};
                    par_wdata = (cp_mode_reg == CP_INIT) ? x_reg : par_rdata_reg;
                end
                t_next = t_reg + EC'(1);
                if (t_reg == EC'(NUM_EVENTS))
                begin
                    t_next = '0;
                    case (cp_mode_reg)
                        CP_INIT:
                        begin
                            if (x_reg == SW'(MAX_STATES - 1))
                            begin
                                i_next  = '0;
                                st_next = S_I_RD;
                            end
                            else
                                x_next = x_reg + SW'(1);
                        end
                        CP_LO:
                        begin
                            x_next       = b_reg;
                            cp_mode_next = CP_HI;
                        end
                        default:
                        begin
                            k_next = k_reg + CW'(1);
                            if ((k_reg + CW'(1)) == qn_reg)
                            begin
                                j_next  = j_reg + CW'(1);
                                st_next = S_J_RD;
                            end
                            else
                                st_next = S_Q_RD;
                        end
                    endcase
                end
            end

            S_I_RD:
            begin
                if (i_reg == n_used)
                begin
                    s_next  = '0;
                    st_next = S_OUT;
                end
                else
                begin
                    par_raddr = {BANK_LIVE, i_reg[SW-1:0]};
                    st_next   = S_I_CHK;
                end
            end

            S_I_CHK:
            begin
                if (par_rdata_reg == i_reg[SW-1:0])
                begin
                    j_next  = i_reg + CW'(1);
                    st_next = S_J_RD;
                end
                else
                begin
                    i_next  = i_reg + CW'(1);
                    st_next = S_I_RD;
                end
            end

            S_J_RD:
            begin
                if (j_reg == n_used)
                begin
                    i_next  = i_reg + CW'(1);
                    st_next = S_I_RD;
                end
                else
                begin
                    par_raddr = {BANK_LIVE, j_reg[SW-1:0]};
                    st_next   = S_J_CHK;
                end
            end

            S_J_CHK:
            begin
                if (par_rdata_reg == j_reg[SW-1:0])
                begin
                    par_we    = 1'b1;
                    par_waddr = {BANK_LIVE, j_reg[SW-1:0]};
                    par_wdata = i_reg[SW-1:0];
                    que_we    = 1'b1;
                    que_waddr = '0;
                    que_wdata = {i_reg[SW-1:0], j_reg[SW-1:0]};
                    qn_next   = CW'(1);
                    k_next    = '0;
                    ok_next   = 1'b1;
                    fin_next  = 1'b0;
                    st_next   = S_Q_RD;
                end
                else
                begin
                    j_next  = j_reg + CW'(1);
                    st_next = S_J_RD;
                end
            end

            S_Q_RD:
            begin
                que_raddr = k_reg[SW-1:0];
                st_next   = S_Q_GOT;
            end

            S_Q_GOT:
            begin
                a_next = que_rdata_reg[2*SW-1:SW];
                b_next = que_rdata_reg[SW-1:0];
                if (fin_reg)
                begin
                    x_next       = que_rdata_reg[2*SW-1:SW];
                    cp_mode_next = CP_LO;
                    t_next       = '0;
                    st_next      = S_COPY;
                end
                else
                    st_next = S_RA;
            end

            S_RA:
            begin
                row_raddr = {BANK_LIVE, a_reg};
                st_next   = S_RB;
            end

            S_RB:
            begin
                row_raddr = {BANK_LIVE, b_reg};
                en_a_next = row_rd[NUM_EVENTS-1:0];
                fb_a_next = row_rd[2*NUM_EVENTS-1:NUM_EVENTS];
                mk_a_next = row_rd[ROW_W-1:2*NUM_EVENTS];
                st_next   = S_RB2;
            end

            S_RB2:
            begin
                en_b_next = row_rd[NUM_EVENTS-1:0];
                fb_b_next = row_rd[2*NUM_EVENTS-1:NUM_EVENTS];
                mk_b_next = row_rd[ROW_W-1:2*NUM_EVENTS];
                st_next   = S_CMP;
            end

            S_CMP:
            begin
                if (!compat)
                begin
                    ok_next  = 1'b0;
                    fin_next = 1'b1;
                    k_next   = '0;
                    st_next  = S_Q_RD;
                end
                else
                begin
                    fb_a_next = fb_a_reg | fb_b_reg;
                    mk_a_next = mk_a_reg | mk_b_reg;
                    e_next    = '0;
                    st_next   = S_EV;
                end
            end

            S_EV:
            begin
                if (e_reg == EC'(NUM_EVENTS))
                begin
                    row_we    = 1'b1;
                    row_waddr = {BANK_LIVE, a_reg};
                    row_wdata = {mk_a_reg, fb_a_reg, en_a_reg};
                    st_next   = S_Q_RD;
                    if ((k_reg + CW'(1)) == qn_reg)
                    begin
                        fin_next = 1'b1;
                        k_next   = '0;
                    end
                    else
                        k_next = k_reg + CW'(1);
                end
                else if (ea && eb)
                begin
                    tgt_raddr = {BANK_LIVE, a_reg, e_idx};
                    st_next   = S_TA;
                end
                else if (eb)
                begin
                    tgt_raddr = {BANK_LIVE, b_reg, e_idx};
                    st_next   = S_CP_EV;
                end
                else
                    e_next = e_reg + EC'(1);
            end

            // event only in the second node: copy it into the first
            S_CP_EV:
            begin
                tgt_we    = 1'b1;
                tgt_waddr = {BANK_LIVE, a_reg, e_idx};
                tgt_wdata = tgt_rdata_reg;
                en_a_next = en_a_reg | e_onehot;
                e_next    = e_reg + EC'(1);
                st_next   = S_EV;
            end

            S_TA:
            begin
                tgt_raddr = {BANK_LIVE, b_reg, e_idx};
                t1_next   = tgt_rdata_reg;
                st_next   = S_TB;
            end

            S_TB:
            begin
                t2_next   = tgt_rdata_reg;
                fx_next   = t1_reg;
                fret_next = FR_C1;
                st_next   = S_F_RD;
            end

            S_F_RD:
            begin
                par_raddr = {BANK_LIVE, fx_reg};
                st_next   = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (par_rdata_reg != fx_reg)
                begin
                    fx_next = par_rdata_reg;
                    st_next = S_F_RD;
                end
                else
                begin
                    case (fret_reg)
                        FR_C1:
                        begin
                            c1_next   = fx_reg;
                            fx_next   = t2_reg;
                            fret_next = FR_C2;
                            st_next   = S_F_RD;
                        end
                        FR_C2:
                            st_next = S_LINK;
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_state_next = s_wide[5:0];
                            out_rep_next   = fx_wide[5:0];
                            out_last_next  = (s_reg + CW'(1)) == n_used;
                            st_next        = S_OUT_WAIT;
                        end
                    endcase
                end
            end

            // fx holds the second root here
            S_LINK:
            begin
                if (c1_reg == fx_reg)
                begin
                    e_next  = e_reg + EC'(1);
                    st_next = S_EV;
                end
                else if ((CW'(lnk_lo) < i_reg) || (qn_reg == CW'(MAX_STATES)))
                begin
                    ok_next  = 1'b0;
                    fin_next = 1'b1;
                    k_next   = '0;
                    st_next  = S_Q_RD;
                end
                else
                begin
                    par_we    = 1'b1;
                    par_waddr = {BANK_LIVE, lnk_hi};
                    par_wdata = lnk_lo;
                    que_we    = 1'b1;
                    que_waddr = qn_reg[SW-1:0];
                    que_wdata = {lnk_lo, lnk_hi};
                    qn_next   = qn_reg + CW'(1);
                    e_next    = e_reg + EC'(1);
                    st_next   = S_EV;
                end
            end

            S_OUT:
            begin
                if (s_reg == n_used)
                    st_next = S_IDLE;
                else
                begin
                    fx_next   = s_idx;
                    fret_next = FR_OUT;
                    st_next   = S_F_RD;
                end
            end

            S_OUT_WAIT:
            begin
                if (results.ready)
                begin
                    out_valid_next = 1'b0;
                    s_next         = s_reg + CW'(1);
                    st_next        = S_OUT;
                end
            end

            default:
                st_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/supervisor_state_merge_reduction_unit.sv =====
// ============================================================================
// supervisor_state_merge_reduction_unit
// Loads an automaton, merges compatible states and reports cluster heads.
// ============================================================================
// Usage:
//   items carries command words. Load words (marks, transition, forbidden
//   event) are taken one per cycle while the unit is idle and give no result.
//   A run word starts the reduction; ready returns high once the last result
//   word is taken and the sequencer has passed S_OUT back to idle.
//   A run first checkpoints all tables, one target entry per cycle. Each
//   candidate state is tested by a parent read. Each queued pair of a merge
//   attempt reads both rows, checks them and walks every event, copying
//   the events found only in the second node; per shared event it reads
//   both targets and runs two root searches. Commit or rollback copies the
//   rows, targets and parents of each pair between the banks.
//   results then carries one word per used state, each after a root
//   search; last_result marks the final word.
//   A stalled receiver holds the result word in the output register and the
//   sequencer waits on it.
//   Reset clears the tables to empty rows with default marks (valid bits,
//   no sweep) and sets num_states_used to 64. The APB register at offset 0
//   is num_states_used; the user must write it only while idle (unchecked).
// ============================================================================
module supervisor_state_merge_reduction_unit #(
    parameter int MAX_STATES = ssmr_pkg::MAX_STATES_DEF,
    parameter int NUM_EVENTS = ssmr_pkg::NUM_EVENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ssmr_in_if.sink                     items,
    ssmr_out_if.source                  results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssmr_pkg::APB_AW-1:0] paddr,
    input  logic [ssmr_pkg::APB_DW-1:0] pwdata,
    output logic [ssmr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ssmr_pkg::*;

    localparam int CW   = $clog2(MAX_STATES + 1);
    localparam int NLIM = (MAX_STATES < OUT_LIMIT) ? MAX_STATES : OUT_LIMIT;

    logic [CFG_W-1:0] num_states_used_reg, num_states_used_next;
    logic [CW-1:0]    n_used;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUM_STATES);

    always_comb
    begin
        num_states_used_next = num_states_used_reg;
        if (cfg_write)
            num_states_used_next = pwdata[CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_states_used_reg <= CFG_W'(CFG_RESET);
        else
            num_states_used_reg <= num_states_used_next;
    end

    assign prdata = (paddr[2] == REG_NUM_STATES) ?
                    {{(APB_DW-CFG_W){1'b0}}, num_states_used_reg} : '0;

    // clamp to 1..NLIM
    always_comb
    begin
        if (num_states_used_reg == '0)
            n_used = CW'(1);
        else if (32'(num_states_used_reg) > 32'(NLIM))
            n_used = CW'(NLIM);
        else
            n_used = CW'(num_states_used_reg);
    end

    ssmr_engine #(
        .MAX_STATES (MAX_STATES),
        .NUM_EVENTS (NUM_EVENTS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .n_used  (n_used)
    );

endmodule

// ===== sim/ssmr_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ssmr_checker
// Watches the command, result and APB ports of the merge reduction unit. It
// keeps its own copy of the automaton tables, repeats the pairwise merge on
// every run word and compares each result word with the oldest expected one.
// ============================================================================
module ssmr_checker
    import ssmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssmr_in_if          items,
    ssmr_out_if         results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          words_seen,
    output int          runs_seen
);

    typedef struct packed {
        logic [5:0] state_id;
        logic [5:0] head;
        logic       last;
    } cluster_word_t;

    cluster_word_t cluster_q[$];

    logic [CFG_W-1:0] states_used;
    logic [31:0]      en_bits [64];
    logic [31:0]      fb_bits [64];
    logic [5:0]       tgt     [64][32];
    logic [3:0]       mark    [64];
    int unsigned      par     [64];
    logic [31:0]      sv_en   [64];
    logic [31:0]      sv_fb   [64];
    logic [5:0]       sv_tgt  [64][32];
    logic [3:0]       sv_mark [64];
    int unsigned      sv_par  [64];
    int unsigned      pq_lo   [64];
    int unsigned      pq_hi   [64];

    function automatic int unsigned root_of(int unsigned x);
        while (par[x] != x)
            x = par[x];
        return x;
    endfunction

    function automatic void keep_row(int unsigned s, bit commit);
        if (commit)
        begin
            sv_en[s] = en_bits[s];
            sv_fb[s] = fb_bits[s];
            sv_tgt[s] = tgt[s];
            sv_mark[s] = mark[s];
            sv_par[s] = par[s];
        end
        else
        begin
            en_bits[s] = sv_en[s];
            fb_bits[s] = sv_fb[s];
            tgt[s] = sv_tgt[s];
            mark[s] = sv_mark[s];
            par[s] = sv_par[s];
        end
    endfunction

    function automatic bit can_join(int unsigned a, int unsigned b);
        logic [4:0] lo_sum;
        logic [4:0] hi_sum;
        lo_sum = 5'(mark[a] & MARK_LO_MASK) + 5'(mark[b] & MARK_LO_MASK);
        hi_sum = 5'(mark[a] & MARK_HI_MASK) + 5'(mark[b] & MARK_HI_MASK);
        if (lo_sum == CONFLICT_LO || hi_sum == CONFLICT_HI)
            return 0;
        if ((fb_bits[a] & en_bits[b]) != 0 || (fb_bits[b] & en_bits[a]) != 0)
            return 0;
        return 1;
    endfunction

    function automatic void attempt_merge(int unsigned ri, int unsigned rj);
        int unsigned qn, k, e, a, b, c1, c2, lo, hi;
        bit ok;
        qn = 1;
        ok = 1;
        par[rj] = ri;
        pq_lo[0] = ri;
        pq_hi[0] = rj;
        for (k = 0; k < qn && ok; k++)
        begin
            a = pq_lo[k];
            b = pq_hi[k];
            if (!can_join(a, b))
            begin
                ok = 0;
                break;
            end
            fb_bits[a] |= fb_bits[b];
            mark[a] |= mark[b];
            for (e = 0; e < 32; e++)
            begin
                if (en_bits[a][e] && en_bits[b][e])
                begin
                    c1 = root_of(tgt[a][e]);
                    c2 = root_of(tgt[b][e]);
                    if (c1 != c2)
                    begin
                        lo = (c1 < c2) ? c1 : c2;
                        hi = (c1 < c2) ? c2 : c1;
                        // cluster below the current head or queue full: give up early
                        if (lo < ri || qn >= 64)
                        begin
                            ok = 0;
                            break;
                        end
                        par[hi] = lo;
                        pq_lo[qn] = lo;
                        pq_hi[qn] = hi;
                        qn++;
                    end
                end
                else if (en_bits[b][e])
                begin
                    en_bits[a][e] = 1'b1;
                    tgt[a][e] = tgt[b][e];
                end
            end
        end
        for (k = 0; k < qn; k++)
        begin
            keep_row(pq_lo[k], ok);
            keep_row(pq_hi[k], ok);
        end
    endfunction

    function automatic void reduce_and_queue();
        int unsigned n, i, j, s;
        cluster_word_t w;
        n = states_used;
        if (n < 1)
            n = 1;
        if (n > 64)
            n = 64;
        for (s = 0; s < 64; s++)
            par[s] = s;
        for (s = 0; s < 64; s++)
            keep_row(s, 1);
        for (i = 0; i < n; i++)
        begin
            if (par[i] != i)
                continue;
            for (j = i + 1; j < n; j++)
            begin
                if (par[j] != j)
                    continue;
                attempt_merge(i, j);
            end
        end
        for (s = 0; s < n; s++)
        begin
            w.state_id = 6'(s);
            w.head = 6'(root_of(s));
            w.last = (s == n - 1);
            cluster_q.push_back(w);
        end
    endfunction

    initial
    begin
        states_used = 7'(CFG_RESET);
        for (int s = 0; s < 64; s++)
        begin
            en_bits[s] = '0;
            fb_bits[s] = '0;
            mark[s] = MARK_RESET;
            par[s] = s;
            for (int e = 0; e < 32; e++)
                tgt[s][e] = '0;
            keep_row(s, 1);
        end
        errors = 0;
        words_seen = 0;
        runs_seen = 0;
    end

    assign pending = cluster_q.size();

    always @(posedge clk)
    begin
        cluster_word_t exp_w;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_STATES)
                states_used = pwdata[CFG_W-1:0];

            if (items.valid && items.ready)
            begin
                case (items.command)
                    CMD_LOAD_MARK:
                        mark[items.state_index] =
                            4'({1'b1, items.ctrl_mark}
                               << (2 * items.plant_mark));
                    CMD_LOAD_TRANS:
                    begin
                        en_bits[items.state_index][items.event_index] = 1'b1;
                        tgt[items.state_index][items.event_index] = items.target_state;
                    end
                    CMD_LOAD_FORBID:
                        fb_bits[items.state_index][items.event_index] = 1'b1;
                    CMD_RUN:
                    begin
                        reduce_and_queue();
                        runs_seen++;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (results.valid && results.ready)
            begin
                words_seen++;
                if (cluster_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word state %0d head %0d",
                             $time, results.result_state, results.cluster_representative);
                end
                else
                begin
                    exp_w = cluster_q.pop_front();
                    if (results.result_state !== exp_w.state_id)
                    begin
                        errors++;
                        $display("%0t: result_state exp %0d got %0d", $time,
                                 exp_w.state_id, results.result_state);
                    end
                    if (results.cluster_representative !== exp_w.head)
                    begin
                        errors++;
                        $display("%0t: cluster_representative of %0d exp %0d got %0d",
                                 $time, exp_w.state_id, exp_w.head,
                                 results.cluster_representative);
                    end
                    if (results.last_result !== exp_w.last)
                    begin
                        errors++;
                        $display("%0t: last_result of %0d exp %0d got %0d", $time,
                                 exp_w.state_id, exp_w.last, results.last_result);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives the merge reduction unit with directed and random automaton loads,
// run words and register writes under varying backpressure; the checker
// beside the unit predicts and compares every result word.
// ============================================================================
module tb;
    import ssmr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          words_seen;
    int          runs_seen;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          loads_sent;
    int          scope;

    ssmr_in_if  cmd_ch ();
    ssmr_out_if res_ch ();

    supervisor_state_merge_reduction_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (cmd_ch),
        .results (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ssmr_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (cmd_ch),
        .results    (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .errors     (errors),
        .pending    (pending),
        .words_seen (words_seen),
        .runs_seen  (runs_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_word(logic [1:0] cmd, logic [5:0] st, logic [4:0] ev,
                             logic [5:0] tg, logic ctrl, logic plant);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.state_index <= st;
        cmd_ch.event_index <= ev;
        cmd_ch.target_state <= tg;
        cmd_ch.ctrl_mark <= ctrl;
        cmd_ch.plant_mark <= plant;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (cmd != CMD_RUN)
            loads_sent++;
    endtask

    // lower valid, then let every pending word drain before touching registers
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_load(int span);
        int pick;
        logic [5:0] st;
        logic [5:0] tg;
        pick = $urandom_range(99);
        st = 6'($urandom_range(span - 1));
        tg = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(span));
        if (pick < 55)
            send_word(CMD_LOAD_TRANS, st, 5'($urandom_range(5)), tg, 1'b0, 1'b0);
        else if (pick < 72)
            send_word(CMD_LOAD_MARK, st, 5'($urandom), 6'($urandom),
                      1'($urandom), 1'($urandom));
        else if (pick < 80)
            send_word(CMD_LOAD_FORBID, st, 5'($urandom_range(5)), 6'($urandom),
                      1'b0, 1'b0);
        else
            // noise anywhere in the fields
            send_word(2'($urandom_range(2)), 6'($urandom), 5'($urandom),
                      6'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial
    begin
        #400_000_000;
        $display("** supervisor_state_merge_reduction_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_LOAD_MARK;
        cmd_ch.state_index <= '0;
        cmd_ch.event_index <= '0;
        cmd_ch.target_state <= '0;
        cmd_ch.ctrl_mark <= 1'b0;
        cmd_ch.plant_mark <= 1'b0;
        tx_idle_pct = 6;
        rx_idle_pct = 69;
        loads_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tables, full 64-state run
        send_word(CMD_RUN, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0);
        settle();
        apb_write(3'd4, 32'd3);     // not a register
        apb_write(3'd0, 32'd6);
        // marks: lo-pair conflict (3 with 2), hi-pair conflict (8 with 12)
        send_word(CMD_LOAD_MARK, 6'd0, 5'd0, 6'd0, 1'b1, 1'b0);
        send_word(CMD_LOAD_MARK, 6'd2, 5'd0, 6'd0, 1'b0, 1'b1);
        send_word(CMD_LOAD_MARK, 6'd3, 5'd31, 6'd63, 1'b1, 1'b1);
        send_word(CMD_LOAD_MARK, 6'd63, 5'd31, 6'd63, 1'b1, 1'b1);
        // shared events pull targets together, one target beyond used states
        send_word(CMD_LOAD_TRANS, 6'd1, 5'd0, 6'd4, 1'b0, 1'b0);
        send_word(CMD_LOAD_TRANS, 6'd4, 5'd0, 6'd5, 1'b0, 1'b0);
        send_word(CMD_LOAD_TRANS, 6'd5, 5'd31, 6'd63, 1'b0, 1'b0);
        send_word(CMD_LOAD_TRANS, 6'd5, 5'd31, 6'd62, 1'b0, 1'b0);
        send_word(CMD_LOAD_TRANS, 6'd63, 5'd31, 6'd0, 1'b1, 1'b1);
        send_word(CMD_LOAD_TRANS, 6'd1, 5'd7, 6'd1, 1'b0, 1'b0);
        // forbidden event against an enabled one, twice (accumulates)
        send_word(CMD_LOAD_FORBID, 6'd3, 5'd7, 6'd0, 1'b0, 1'b0);
        send_word(CMD_LOAD_FORBID, 6'd3, 5'd7, 6'd0, 1'b0, 1'b0);
        send_word(CMD_LOAD_FORBID, 6'd63, 5'd0, 6'd0, 1'b0, 1'b0);
        send_word(CMD_RUN, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0);
        send_word(CMD_RUN, 6'd63, 5'd31, 6'd63, 1'b1, 1'b1);
        settle();
        apb_write(3'd0, 32'd0);     // saturates to one state
        send_word(CMD_RUN, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0);
        settle();
        apb_write(3'd0, 32'h7f);    // saturates to 64
        send_word(CMD_RUN, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0);
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 69 : 0;
            rx_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 6 : 0;
            for (int grp = 0; grp < 5; grp++)
            begin
                scope = ($urandom_range(4) == 0) ? $urandom_range(13, 20)
                                                 : $urandom_range(2, 12);
                apb_write(3'd0, 32'(scope));
                repeat (28)
                    random_load(scope);
                send_word(CMD_RUN, 6'($urandom), 5'($urandom), 6'($urandom),
                          1'($urandom), 1'($urandom));
                if ($urandom_range(2) == 0)
                    send_word(CMD_RUN, 6'd0, 5'd0, 6'd0, 1'b0, 1'b0);
                settle();
            end
        end

        $display("covered %0d load words and %0d runs, %0d result words checked",
                 loads_sent, runs_seen, words_seen);
        $display("state counts from 1 to 64, three backpressure mixes");
        if (errors == 0 && pending == 0)
            $display("** supervisor_state_merge_reduction_unit: PASSED **");
        else
            $display("** supervisor_state_merge_reduction_unit: FAILED **");
        $finish;
    end

endmodule
